/* rtl/qds_pkg.sv */
`timescale 1ns / 1ps

package qds_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned ERR_W   = 31;
  localparam int unsigned CPR_W   = 16;
  localparam int unsigned CFG_W   = 32;

  typedef enum logic [0:0] {
    CFG_UPDATE_PERIOD = 1'b0,
    CFG_COUNTS_PER_REV = 1'b1
  } cfg_reg_e;

  typedef enum logic [0:0] {
    KIND_PHASE  = 1'b0,
    KIND_UPDATE = 1'b1
  } kind_e;

  typedef struct packed {
    logic              op;
    logic              phase_a;
    logic              phase_b;
    logic [TIME_W-1:0] time_us;
  } in_item_t;

  typedef struct packed {
    logic signed [COUNT_W-1:0] position_count;
    logic                      moving_forward;
    logic [ERR_W-1:0]          error_total;
    logic signed [COUNT_W-1:0] step_delta;
    logic [CPR_W-1:0]          angle_counts;
    logic [CPR_W-1:0]          angle_turn_q16;
    logic                      updated;
  } out_item_t;

  typedef struct packed {
    kind_e             kind;
    logic [1:0]        ab;
    logic [TIME_W-1:0] time_us;
  } cmd_t;

  typedef struct packed {
    logic [TIME_W-1:0] update_period_us;
    logic [CPR_W-1:0]  counts_per_rev;
  } cfg_t;

endpackage

/* rtl/qds_front.sv */
`timescale 1ns / 1ps

module qds_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  qds_pkg::in_item_t in_data,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output qds_pkg::cmd_t     cmd_data
);

  logic          vld_r;
  logic          vld_nxt;
  qds_pkg::cmd_t cmd_r;
  qds_pkg::cmd_t cmd_nxt;

  assign in_ready  = !vld_r || cmd_ready;
  assign cmd_valid = vld_r;
  assign cmd_data  = cmd_r;

  always_comb begin
    vld_nxt = vld_r;
    cmd_nxt = cmd_r;
    if (vld_r && cmd_ready) begin
      vld_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      vld_nxt         = 1'b1;
      cmd_nxt.kind    = in_data.op ? qds_pkg::KIND_UPDATE : qds_pkg::KIND_PHASE;
      cmd_nxt.ab      = {in_data.phase_a, in_data.phase_b};
      cmd_nxt.time_us = in_data.time_us;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    cmd_r <= cmd_nxt;
  end

endmodule

/* rtl/qds_fifo.sv */
`timescale 1ns / 1ps

module qds_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  qds_pkg::cmd_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output qds_pkg::cmd_t pop_data
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  qds_pkg::cmd_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r;
  logic [AW-1:0] rd_ptr_nxt;
  logic [CW-1:0] fill_r;
  logic [CW-1:0] fill_nxt;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (fill_r != FULL);
  assign pop_valid  = (fill_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/qds_back.sv */
`timescale 1ns / 1ps

module qds_back (
  input  logic               clk,
  input  logic               rst_n,
  input  qds_pkg::cfg_t      cfg,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  qds_pkg::cmd_t      cmd_data,
  output logic               out_valid,
  input  logic               out_ready,
  output qds_pkg::out_item_t out_data
);

  localparam int unsigned CW = qds_pkg::COUNT_W;
  localparam int unsigned PW = qds_pkg::CPR_W;
  localparam int unsigned SW = $clog2(CW);
  localparam logic [SW-1:0] MOD_LAST = SW'(CW - 1);
  localparam logic [SW-1:0] DIV_LAST = SW'(PW - 1);
  localparam logic [qds_pkg::ERR_W-1:0] ERR_MAX = '1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MOD  = 5'b00010,
    S_FIX  = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [1:0]                last_ab_r, last_ab_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic                      dir_r, dir_nxt;
  logic [qds_pkg::ERR_W-1:0] err_r, err_nxt;
  logic [CW-1:0]             cnt_upd_r, cnt_upd_nxt;
  logic [qds_pkg::TIME_W-1:0] time_upd_r, time_upd_nxt;
  logic [CW-1:0]             delta_r, delta_nxt;
  logic [PW-1:0]             angle_r, angle_nxt;
  logic [PW-1:0]             frac_r, frac_nxt;
  logic [CW-1:0]             mag_r, mag_nxt;
  logic                      neg_r, neg_nxt;
  logic [PW-1:0]             rem_r, rem_nxt;
  logic [PW-1:0]             quo_r, quo_nxt;
  logic [SW-1:0]             step_r, step_nxt;
  logic                      out_valid_r, out_valid_nxt;
  qds_pkg::out_item_t        out_data_r, out_data_nxt;

  logic                       out_free;
  logic                       take;
  logic [3:0]                 code;
  logic [qds_pkg::TIME_W-1:0] elapsed;
  logic [PW:0]                rem_sh;
  logic [PW:0]                rem_sub;
  logic                       ge;
  logic [PW-1:0]              rem_step;
  logic [PW-1:0]              angle_fix;
  logic                       emit;
  logic                       emit_upd;

  assign out_free  = !out_valid_r || out_ready;
  assign take      = cmd_valid && (state_r == S_IDLE) && out_free;
  assign cmd_ready = take;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign code    = {cmd_data.ab, last_ab_r};
  assign elapsed = cmd_data.time_us - time_upd_r;

  assign rem_sh   = {rem_r, (state_r == S_MOD) ? mag_r[CW-1] : 1'b0};
  assign ge       = rem_sh >= {1'b0, cfg.counts_per_rev};
  assign rem_sub  = rem_sh - {1'b0, cfg.counts_per_rev};
  assign rem_step = ge ? rem_sub[PW-1:0] : rem_sh[PW-1:0];
  assign angle_fix = (neg_r && (rem_r != '0)) ? cfg.counts_per_rev - rem_r : rem_r;

  always_comb begin
    state_nxt     = state_r;
    last_ab_nxt   = last_ab_r;
    count_nxt     = count_r;
    dir_nxt       = dir_r;
    err_nxt       = err_r;
    cnt_upd_nxt   = cnt_upd_r;
    time_upd_nxt  = time_upd_r;
    delta_nxt     = delta_r;
    angle_nxt     = angle_r;
    frac_nxt      = frac_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    step_nxt      = step_r;
    emit          = 1'b0;
    emit_upd      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (take) begin
          if (cmd_data.kind == qds_pkg::KIND_PHASE) begin
            emit = 1'b1;
            if (code inside {4'h1, 4'h7, 4'h8, 4'hE}) begin
              count_nxt   = count_r + 1'b1;
              dir_nxt     = 1'b1;
              last_ab_nxt = cmd_data.ab;
            end else if (code inside {4'h2, 4'h4, 4'hB, 4'hD}) begin
              count_nxt   = count_r - 1'b1;
              dir_nxt     = 1'b0;
              last_ab_nxt = cmd_data.ab;
            end else if (err_r != ERR_MAX) begin
              err_nxt = err_r + 1'b1;
            end
          end else if (elapsed < cfg.update_period_us) begin
            emit = 1'b1;
          end else begin
            delta_nxt    = count_r - cnt_upd_r;
            cnt_upd_nxt  = count_r;
            time_upd_nxt = cmd_data.time_us;
            if (cfg.counts_per_rev == '0) begin
              angle_nxt = '0;
              frac_nxt  = '0;
              emit      = 1'b1;
              emit_upd  = 1'b1;
            end else begin
              neg_nxt   = count_r[CW-1];
              mag_nxt   = count_r[CW-1] ? -count_r : count_r;
              rem_nxt   = '0;
              step_nxt  = '0;
              state_nxt = S_MOD;
            end
          end
        end
      end
      S_MOD: begin
        rem_nxt  = rem_step;
        mag_nxt  = {mag_r[CW-2:0], 1'b0};
        step_nxt = step_r + 1'b1;
        if (step_r == MOD_LAST) begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        angle_nxt = angle_fix;
        rem_nxt   = angle_fix;
        step_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt  = rem_step;
        quo_nxt  = {quo_r[PW-2:0], ge};
        step_nxt = step_r + 1'b1;
        if (step_r == DIV_LAST) begin
          frac_nxt  = {quo_r[PW-2:0], ge};
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_upd  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt               = 1'b1;
      out_data_nxt.position_count = count_nxt;
      out_data_nxt.moving_forward = dir_nxt;
      out_data_nxt.error_total    = err_nxt;
      out_data_nxt.step_delta     = delta_nxt;
      out_data_nxt.angle_counts   = angle_nxt;
      out_data_nxt.angle_turn_q16 = frac_nxt;
      out_data_nxt.updated        = emit_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_ab_r   <= '0;
      count_r     <= '0;
      dir_r       <= 1'b1;
      err_r       <= '0;
      cnt_upd_r   <= '0;
      time_upd_r  <= '0;
      delta_r     <= '0;
      angle_r     <= '0;
      frac_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_ab_r   <= last_ab_nxt;
      count_r     <= count_nxt;
      dir_r       <= dir_nxt;
      err_r       <= err_nxt;
      cnt_upd_r   <= cnt_upd_nxt;
      time_upd_r  <= time_upd_nxt;
      delta_r     <= delta_nxt;
      angle_r     <= angle_nxt;
      frac_r      <= frac_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    step_r     <= step_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

/* rtl/quadrature_decoder_with_sampler_unit.sv */
`timescale 1ns / 1ps

// x4 quadrature decoder with a periodic position sampler. Phase samples and
// update requests enter through a classifying front stage and a short command
// queue; a phase sample, or an update request that finds the period not yet
// elapsed, yields a registered result in the cycle after it leaves the queue.
// An update that completes a period runs a shared restoring divider, one bit
// per cycle: 32 steps for the count modulo counts_per_rev, one fix-up step that
// folds a negative count into range and 16 steps for the Q0.16 turn fraction,
// then a done state that hands the result out once the output register is free
// (counts_per_rev of 0 skips the divider, giving angle and fraction 0). The
// back end takes one item at a time, and only with a free output register.
// Configuration writes are always ready and also reach an update in the divider.

module quadrature_decoder_with_sampler_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  qds_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output qds_pkg::out_item_t         out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  qds_pkg::cfg_reg_e          cfg_index,
  input  logic [qds_pkg::CFG_W-1:0]  cfg_wdata
);

  qds_pkg::cfg_t cfg_r;
  qds_pkg::cfg_t cfg_nxt;
  logic          f_valid;
  logic          f_ready;
  qds_pkg::cmd_t f_data;
  logic          q_valid;
  logic          q_ready;
  qds_pkg::cmd_t q_data;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        qds_pkg::CFG_UPDATE_PERIOD: cfg_nxt.update_period_us = cfg_wdata;
        qds_pkg::CFG_COUNTS_PER_REV: begin
          cfg_nxt.counts_per_rev = cfg_wdata[qds_pkg::CPR_W-1:0];
        end
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.update_period_us <= 32'd1000;
      cfg_r.counts_per_rev   <= 16'd1024;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  qds_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd_data  (f_data)
  );

  qds_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  qds_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd_data  (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
